@@ sv/tlf_pkg.sv @@
// shared types, constants and register codes of the thermal load frequency limiter
package tlf_pkg;

   // field widths
   localparam int FreqW   = 22;
   localparam int TempW   = 8;
   localparam int ThrW    = 7;
   localparam int LoadW   = 14;
   localparam int CountW  = 32;
   localparam int NCount  = 7;
   localparam int IdleIdx = 3;
   localparam int TotalW  = CountW + 3;
   localparam int ProdW   = CountW + LoadW;
   localparam int RemW    = TotalW + 1;
   localparam int StepW   = $clog2(CountW);
   localparam int RegIdxW = 3;

   // packed stream widths
   localparam int ReqDataW = TempW + NCount * CountW;
   localparam int RspBits  = FreqW + LoadW;
   localparam int RspDataW = ((RspBits + 7) / 8) * 8;

   // load scale and whole-percent thresholds in hundredths
   localparam logic [LoadW-1:0] LoadFull   = LoadW'(10000);
   localparam int               PctScale   = 100;
   localparam logic [LoadW-1:0] LoadHiMin  = LoadW'((49 + 1) * PctScale);
   localparam logic [LoadW-1:0] LoadMidMin = LoadW'((20 + 1) * PctScale);

   // register reset values
   localparam logic [FreqW-1:0] PeakRst   = FreqW'(1400000);
   localparam logic [FreqW-1:0] Level0Rst = FreqW'(1000000);
   localparam logic [FreqW-1:0] Level1Rst = FreqW'(800000);
   localparam logic [FreqW-1:0] FloorRst  = FreqW'(400000);
   localparam logic [ThrW-1:0]  ClearRst  = ThrW'(60);
   localparam logic [ThrW-1:0]  Band0Rst  = ThrW'(65);
   localparam logic [ThrW-1:0]  Band1Rst  = ThrW'(70);
   localparam logic [ThrW-1:0]  Band2Rst  = ThrW'(75);

   // register indexes
   typedef enum logic [RegIdxW-1:0] {
      REG_PEAK   = 3'd0,
      REG_LEVEL0 = 3'd1,
      REG_LEVEL1 = 3'd2,
      REG_FLOOR  = 3'd3,
      REG_CLEAR  = 3'd4,
      REG_BAND0  = 3'd5,
      REG_BAND1  = 3'd6,
      REG_BAND2  = 3'd7
   } reg_idx_type;

   // load unit sequencer
   typedef enum logic [4:0] {
      LU_IDLE  = 5'b00001,
      LU_DELTA = 5'b00010,
      LU_MUL   = 5'b00100,
      LU_DIV   = 5'b01000,
      LU_DONE  = 5'b10000
   } lu_state_type;

   // top level sequencer
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_BUSY   = 3'b010,
      ST_FINISH = 3'b100
   } top_state_type;

   typedef logic [NCount-1:0][CountW-1:0] counts_type;

   // status from the load unit
   typedef struct packed {
      logic             done;
      logic             total_zero;
      logic [LoadW-1:0] quotient;
   } lu_status_type;

endpackage

@@ sv/thermal_load_freq_limiter_core.sv @@
// top level of the thermal and load driven frequency limiter
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | req_tdata, req_tuser
//  rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// a normal request runs the bit-serial counter pass, 1 multiply and 14 divide steps in the
// load unit, then hands off through the final stage to the output register; a boost request
// skips the load unit and goes straight to the final stage; one request is in work at a time,
// and the next one is taken while the previous response still waits in the output register
// reset is synchronous, restores the register defaults and clears the counter snapshot
// a stalled response holds the finished request in the final stage
module thermal_load_freq_limiter_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // temperature, user, system, nice, idle, wait, irq, softirq ticks
   input  logic [tlf_pkg::ReqDataW-1:0]   req_tdata,
   // boost, die_error
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // max_freq_khz, load_x100, zero fill
   output logic [tlf_pkg::RspDataW-1:0]   rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tlf_pkg::RegIdxW-1:0]    csr_index,
   input  logic [tlf_pkg::FreqW-1:0]      csr_data
);

   tlf_pkg::top_state_type       state_ff;
   tlf_pkg::lu_status_type       lu_status;
   tlf_pkg::counts_type          cur_counts;
   logic                         req_fire;
   logic                         lu_start;
   logic                         boost_ff;
   logic                         die_ff;
   logic [tlf_pkg::TempW-1:0]    temp_ff;
   logic [tlf_pkg::FreqW-1:0]    peak_ff;
   logic [tlf_pkg::FreqW-1:0]    level0_ff;
   logic [tlf_pkg::FreqW-1:0]    level1_ff;
   logic [tlf_pkg::FreqW-1:0]    floor_ff;
   logic [tlf_pkg::ThrW-1:0]     clear_ff;
   logic [tlf_pkg::ThrW-1:0]     band0_ff;
   logic [tlf_pkg::ThrW-1:0]     band1_ff;
   logic [tlf_pkg::ThrW-1:0]     band2_ff;
   logic [tlf_pkg::LoadW-1:0]    last_load_ff;
   logic [tlf_pkg::LoadW-1:0]    last_load_in;
   logic                         under_ff;
   logic                         under_in;
   logic                         min_ff;
   logic                         min_in;
   logic                         danger_ff;
   logic                         danger_in;
   logic [tlf_pkg::FreqW-1:0]    cap_in;
   logic                         load_hi;
   logic                         load_mid;
   logic                         lt_clear;
   logic                         lt_band0;
   logic                         lt_band1;
   logic                         lt_band2;
   logic                         out_free;
   logic                         rsp_valid_ff;
   logic [tlf_pkg::FreqW-1:0]    rsp_freq_ff;
   logic [tlf_pkg::LoadW-1:0]    rsp_load_ff;

   // signed temperature below an unsigned threshold
   function automatic logic temp_below(input logic [tlf_pkg::TempW-1:0] t,
                                       input logic [tlf_pkg::ThrW-1:0] thr);
      temp_below = t[tlf_pkg::TempW-1] | (t[tlf_pkg::ThrW-1:0] < thr);
   endfunction

   assign req_fire   = req_tvalid & req_tready;
   assign req_tready = (state_ff == tlf_pkg::ST_IDLE);
   assign lu_start   = req_fire & ~req_tuser[0];
   assign csr_ready  = 1'b1;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // unpack the counters
   always_comb begin
      for (int i = 0; i < tlf_pkg::NCount; i++) begin
         cur_counts[i] = req_tdata[tlf_pkg::TempW + i*tlf_pkg::CountW +: tlf_pkg::CountW];
      end
   end

   tlf_load_unit u_load (
      .clock      (clock),
      .reset      (reset),
      .start      (lu_start),
      .cur_counts (cur_counts),
      .status     (lu_status)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff   <= tlf_pkg::PeakRst;
         level0_ff <= tlf_pkg::Level0Rst;
         level1_ff <= tlf_pkg::Level1Rst;
         floor_ff  <= tlf_pkg::FloorRst;
         clear_ff  <= tlf_pkg::ClearRst;
         band0_ff  <= tlf_pkg::Band0Rst;
         band1_ff  <= tlf_pkg::Band1Rst;
         band2_ff  <= tlf_pkg::Band2Rst;
      end else if (csr_valid & csr_ready) begin
         case (csr_index)
            tlf_pkg::REG_PEAK:   peak_ff   <= csr_data;
            tlf_pkg::REG_LEVEL0: level0_ff <= csr_data;
            tlf_pkg::REG_LEVEL1: level1_ff <= csr_data;
            tlf_pkg::REG_FLOOR:  floor_ff  <= csr_data;
            tlf_pkg::REG_CLEAR:  clear_ff  <= csr_data[tlf_pkg::ThrW-1:0];
            tlf_pkg::REG_BAND0:  band0_ff  <= csr_data[tlf_pkg::ThrW-1:0];
            tlf_pkg::REG_BAND1:  band1_ff  <= csr_data[tlf_pkg::ThrW-1:0];
            tlf_pkg::REG_BAND2:  band2_ff  <= csr_data[tlf_pkg::ThrW-1:0];
            default: begin
            end
         endcase
      end
   end

   // request fields held for the final stage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         boost_ff <= req_tuser[0];
         die_ff   <= req_tuser[1];
         temp_ff  <= req_tdata[tlf_pkg::TempW-1:0];
      end
   end

   // new load, band decode and cap choice
   always_comb begin
      last_load_in = lu_status.total_zero ? last_load_ff
                                          : (tlf_pkg::LoadFull - lu_status.quotient);
      load_hi  = last_load_in >= tlf_pkg::LoadHiMin;
      load_mid = last_load_in >= tlf_pkg::LoadMidMin;
      lt_clear = temp_below(temp_ff, clear_ff);
      lt_band0 = temp_below(temp_ff, band0_ff);
      lt_band1 = temp_below(temp_ff, band1_ff);
      lt_band2 = temp_below(temp_ff, band2_ff);

      under_in  = under_ff & ~lt_clear;
      min_in    = min_ff & ~lt_clear;
      danger_in = danger_ff & ~lt_clear;
      cap_in    = '0;
      if (lt_band0) begin
         danger_in = 1'b0;
         min_in    = 1'b0;
         if (load_hi) cap_in = under_in ? level0_ff : peak_ff;
         else if (load_mid) cap_in = level0_ff;
         else cap_in = level1_ff;
      end else if (lt_band1) begin
         danger_in = 1'b0;
         under_in  = 1'b1;
         if (load_hi) cap_in = min_in ? level1_ff : level0_ff;
         else cap_in = level1_ff;
      end else if (lt_band2) begin
         min_in = 1'b1;
         cap_in = load_hi ? level1_ff : floor_ff;
      end else begin
         danger_in = 1'b1;
      end
      if (die_ff | danger_in) cap_in = floor_ff;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlf_pkg::ST_IDLE;
      end else begin
         case (state_ff)
            tlf_pkg::ST_IDLE: begin
               if (req_fire) state_ff <= req_tuser[0] ? tlf_pkg::ST_FINISH : tlf_pkg::ST_BUSY;
            end
            tlf_pkg::ST_BUSY: begin
               if (lu_status.done) state_ff <= tlf_pkg::ST_FINISH;
            end
            tlf_pkg::ST_FINISH: begin
               if (out_free) state_ff <= tlf_pkg::ST_IDLE;
            end
            default: begin
               state_ff <= tlf_pkg::ST_IDLE;
            end
         endcase
      end
   end

   // load and limit flags, left alone by boost requests
   always_ff @(posedge clock) begin
      if (reset) begin
         last_load_ff <= '0;
         under_ff     <= 1'b0;
         min_ff       <= 1'b0;
         danger_ff    <= 1'b0;
      end else if ((state_ff == tlf_pkg::ST_FINISH) & out_free & ~boost_ff) begin
         last_load_ff <= last_load_in;
         under_ff     <= under_in;
         min_ff       <= min_in;
         danger_ff    <= danger_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == tlf_pkg::ST_FINISH) & out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == tlf_pkg::ST_FINISH) & out_free) begin
         rsp_freq_ff <= boost_ff ? peak_ff : cap_in;
         rsp_load_ff <= boost_ff ? last_load_ff : last_load_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tlf_pkg::RspDataW - tlf_pkg::RspBits){1'b0}}, rsp_load_ff, rsp_freq_ff};

endmodule

@@ sv/tlf_load_unit.sv @@
// bit-serial counter deltas, snapshot update and restoring divider for the idle share
module tlf_load_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  tlf_pkg::counts_type   cur_counts,
   output tlf_pkg::lu_status_type status
);

   localparam logic [tlf_pkg::StepW-1:0] LastBit  = tlf_pkg::StepW'(tlf_pkg::CountW - 1);
   localparam logic [tlf_pkg::StepW-1:0] LastStep = tlf_pkg::StepW'(tlf_pkg::LoadW - 1);

   tlf_pkg::lu_state_type              state_ff;
   tlf_pkg::counts_type                cur_ff;
   tlf_pkg::counts_type                prev_ff;
   logic [tlf_pkg::NCount-1:0]         borrow_ff;
   logic [tlf_pkg::NCount-1:0]         borrow_in;
   logic [tlf_pkg::NCount-1:0]         dbit;
   logic [2:0]                         carry_ff;
   logic [3:0]                         colsum;
   logic [tlf_pkg::CountW-1:0]         tlow_ff;
   logic [tlf_pkg::CountW-1:0]         idle_ff;
   logic [tlf_pkg::StepW-1:0]          step_ff;
   logic [tlf_pkg::TotalW-1:0]         total;
   logic [tlf_pkg::ProdW-1:0]          prod;
   logic [tlf_pkg::RemW-1:0]           rem_ff;
   logic [tlf_pkg::RemW-1:0]           trial;
   logic                               fits;
   logic [tlf_pkg::LoadW-1:0]          nlow_ff;
   logic [tlf_pkg::LoadW-1:0]          q_ff;

   // one bit column of the seven serial subtractors and the column adder
   always_comb begin
      colsum = {1'b0, carry_ff};
      for (int i = 0; i < tlf_pkg::NCount; i++) begin
         dbit[i]      = cur_ff[i][0] ^ prev_ff[i][0] ^ borrow_ff[i];
         borrow_in[i] = (~cur_ff[i][0] & prev_ff[i][0])
                      | (~(cur_ff[i][0] ^ prev_ff[i][0]) & borrow_ff[i]);
         colsum       = colsum + {3'b000, dbit[i]};
      end
   end

   assign total = {carry_ff, tlow_ff};

   // idle delta scaled by the full load constant
   assign prod = {{tlf_pkg::LoadW{1'b0}}, idle_ff}
               * {{tlf_pkg::CountW{1'b0}}, tlf_pkg::LoadFull};

   // one restoring divide step
   assign trial = {rem_ff[tlf_pkg::RemW-2:0], nlow_ff[tlf_pkg::LoadW-1]};
   assign fits  = trial >= {1'b0, total};

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlf_pkg::LU_IDLE;
      end else begin
         case (state_ff)
            tlf_pkg::LU_IDLE: begin
               if (start) state_ff <= tlf_pkg::LU_DELTA;
            end
            tlf_pkg::LU_DELTA: begin
               if (step_ff == LastBit) state_ff <= tlf_pkg::LU_MUL;
            end
            tlf_pkg::LU_MUL: begin
               state_ff <= tlf_pkg::LU_DIV;
            end
            tlf_pkg::LU_DIV: begin
               if (step_ff == LastStep) state_ff <= tlf_pkg::LU_DONE;
            end
            tlf_pkg::LU_DONE: begin
               state_ff <= tlf_pkg::LU_IDLE;
            end
            default: begin
               state_ff <= tlf_pkg::LU_IDLE;
            end
         endcase
      end
   end

   // counter snapshot, shifted in one bit per cycle behind the deltas
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (state_ff == tlf_pkg::LU_DELTA) begin
         for (int i = 0; i < tlf_pkg::NCount; i++) begin
            prev_ff[i] <= {cur_ff[i][0], prev_ff[i][tlf_pkg::CountW-1:1]};
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         tlf_pkg::LU_IDLE: begin
            cur_ff <= cur_counts;
            // clear only on start so the finished total holds while the response waits
            if (start) begin
               borrow_ff <= '0;
               carry_ff  <= '0;
               step_ff   <= '0;
            end
         end
         tlf_pkg::LU_DELTA: begin
            for (int i = 0; i < tlf_pkg::NCount; i++) begin
               cur_ff[i] <= {1'b0, cur_ff[i][tlf_pkg::CountW-1:1]};
            end
            borrow_ff <= borrow_in;
            carry_ff  <= colsum[3:1];
            tlow_ff   <= {colsum[0], tlow_ff[tlf_pkg::CountW-1:1]};
            idle_ff   <= {dbit[tlf_pkg::IdleIdx], idle_ff[tlf_pkg::CountW-1:1]};
            step_ff   <= step_ff + 1'b1;
         end
         tlf_pkg::LU_MUL: begin
            rem_ff  <= {{(tlf_pkg::RemW - tlf_pkg::CountW){1'b0}},
                        prod[tlf_pkg::ProdW-1:tlf_pkg::LoadW]};
            nlow_ff <= prod[tlf_pkg::LoadW-1:0];
            q_ff    <= '0;
            step_ff <= '0;
         end
         tlf_pkg::LU_DIV: begin
            rem_ff  <= fits ? (trial - {1'b0, total}) : trial;
            q_ff    <= {q_ff[tlf_pkg::LoadW-2:0], fits};
            nlow_ff <= {nlow_ff[tlf_pkg::LoadW-2:0], 1'b0};
            step_ff <= step_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign status.done       = (state_ff == tlf_pkg::LU_DONE);
   assign status.total_zero = (total == '0);
   assign status.quotient   = q_ff;

endmodule

@@ sv/tlf_checker.sv @@
// port-level checks of the frequency limiter and their attachment to the top level
module tlf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tlf_pkg::RspDataW-1:0]   rsp_tdata
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // load never exceeds full scale and the fill stays zero
   a_load_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[tlf_pkg::RspBits-1:tlf_pkg::FreqW] <= tlf_pkg::LoadFull
         && rsp_tdata[tlf_pkg::RspDataW-1:tlf_pkg::RspBits] == '0)
      else $error("load out of range or fill not zero");

   // a request under way blocks the next one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

endmodule

bind thermal_load_freq_limiter_core tlf_checker u_tlf_checker (.*);

@@ dv/tb_top.sv @@
// self-checking testbench for the thermal load frequency limiter core

// one sample request as the testbench sees it
typedef struct packed {
   logic                 boost;
   logic                 die_error;
   logic [7:0]           temperature;
   tlf_pkg::counts_type  ticks;
} sample_type;

// predicts the frequency cap and load of each sample and checks the responses
class cap_scoreboard;
   typedef struct packed {
      logic [tlf_pkg::LoadW-1:0] load_x100;
      logic [tlf_pkg::FreqW-1:0] max_freq_khz;
   } cap_result_type;

   cap_result_type           pending_caps[$];
   int                       errors;

   logic [tlf_pkg::FreqW-1:0] peak_khz, level0_khz, level1_khz, floor_khz;
   logic [tlf_pkg::ThrW-1:0]  clear_thr, band0_thr, band1_thr, band2_thr;

   tlf_pkg::counts_type       snapshot;
   logic [tlf_pkg::LoadW-1:0] held_load;
   bit                        under_set, min_set, danger_set;

   function new();
      errors     = 0;
      peak_khz   = tlf_pkg::PeakRst;
      level0_khz = tlf_pkg::Level0Rst;
      level1_khz = tlf_pkg::Level1Rst;
      floor_khz  = tlf_pkg::FloorRst;
      clear_thr  = tlf_pkg::ClearRst;
      band0_thr  = tlf_pkg::Band0Rst;
      band1_thr  = tlf_pkg::Band1Rst;
      band2_thr  = tlf_pkg::Band2Rst;
      snapshot   = '0;
      held_load  = '0;
      under_set  = 0;
      min_set    = 0;
      danger_set = 0;
   endfunction

   // register write, thresholds keep only their low bits
   function void write_register(tlf_pkg::reg_idx_type idx, logic [tlf_pkg::FreqW-1:0] value);
      case (idx)
         tlf_pkg::REG_PEAK:   peak_khz   = value;
         tlf_pkg::REG_LEVEL0: level0_khz = value;
         tlf_pkg::REG_LEVEL1: level1_khz = value;
         tlf_pkg::REG_FLOOR:  floor_khz  = value;
         tlf_pkg::REG_CLEAR:  clear_thr  = value[tlf_pkg::ThrW-1:0];
         tlf_pkg::REG_BAND0:  band0_thr  = value[tlf_pkg::ThrW-1:0];
         tlf_pkg::REG_BAND1:  band1_thr  = value[tlf_pkg::ThrW-1:0];
         tlf_pkg::REG_BAND2:  band2_thr  = value[tlf_pkg::ThrW-1:0];
         default: ;
      endcase
   endfunction

   // accepted request: update the predicted state and queue the expected cap
   function void note_sample(sample_type s);
      cap_result_type  r;
      logic [34:0]     total;
      logic [31:0]     delta, idle_delta;
      logic [63:0]     scaled;
      int              t, pct;
      logic [tlf_pkg::FreqW-1:0] cap;
      if (s.boost) begin
         r.max_freq_khz = peak_khz;
         r.load_x100    = held_load;
         pending_caps.push_back(r);
         return;
      end
      // wrapping deltas against the snapshot, wide total
      total      = '0;
      idle_delta = '0;
      for (int i = 0; i < tlf_pkg::NCount; i++) begin
         delta = s.ticks[i] - snapshot[i];
         total = total + 35'(delta);
         if (i == tlf_pkg::IdleIdx) idle_delta = delta;
         snapshot[i] = s.ticks[i];
      end
      // zero total keeps the previous load
      if (total != 0) begin
         scaled    = (64'(idle_delta) * 64'd10000) / 64'(total);
         held_load = tlf_pkg::LoadW'(64'd10000 - scaled);
      end
      t   = $signed(s.temperature);
      pct = held_load / 100;
      cap = '0;
      if (t < int'(clear_thr)) begin
         under_set  = 0;
         min_set    = 0;
         danger_set = 0;
      end
      // temperature bands, checked in order without assuming they ascend
      if (t < int'(band0_thr)) begin
         danger_set = 0;
         min_set    = 0;
         if (pct > 49)      cap = under_set ? level0_khz : peak_khz;
         else if (pct > 20) cap = level0_khz;
         else               cap = level1_khz;
      end else if (t < int'(band1_thr)) begin
         danger_set = 0;
         under_set  = 1;
         if (pct > 49) cap = min_set ? level1_khz : level0_khz;
         else          cap = level1_khz;
      end else if (t < int'(band2_thr)) begin
         min_set = 1;
         cap     = (pct > 49) ? level1_khz : floor_khz;
      end else begin
         danger_set = 1;
      end
      if (s.die_error || danger_set) cap = floor_khz;
      r.max_freq_khz = cap;
      r.load_x100    = held_load;
      pending_caps.push_back(r);
   endfunction

   // accepted response: compare with the oldest expectation
   function void check_cap(logic [tlf_pkg::RspDataW-1:0] data);
      cap_result_type want;
      logic [tlf_pkg::FreqW-1:0] got_freq;
      logic [tlf_pkg::LoadW-1:0] got_load;
      got_freq = data[tlf_pkg::FreqW-1:0];
      got_load = data[tlf_pkg::FreqW +: tlf_pkg::LoadW];
      if (pending_caps.size() == 0) begin
         $error("unexpected response max_freq_khz %0d load_x100 %0d", got_freq, got_load);
         errors++;
         return;
      end
      want = pending_caps.pop_front();
      if (got_freq !== want.max_freq_khz) begin
         $error("max_freq_khz expected %0d actual %0d", want.max_freq_khz, got_freq);
         errors++;
      end
      if (got_load !== want.load_x100) begin
         $error("load_x100 expected %0d actual %0d", want.load_x100, got_load);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import tlf_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ReqDataW-1:0]   req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RspDataW-1:0]   rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [RegIdxW-1:0]    csr_index  = REG_PEAK;
   logic [FreqW-1:0]      csr_data   = '0;

   cap_scoreboard         board;
   counts_type            tick_now;
   int                    thr_now[4];
   logic [10:0]           stall_count = '0;

   thermal_load_freq_limiter_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // reset for the first cycles only
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // hard stop
   initial begin
      #8000000;
      $display("tb_top NOT OK");
      $finish;
   end

   // response side: check accepted responses, stall in changing patterns
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_cap(rsp_tdata);
         stall_count <= stall_count + 1'b1;
         case (stall_count[10:9])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= 1'($urandom_range(0, 1));
            2'd2: rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= (stall_count[4:0] < 5'd20);
         endcase
      end
   end

   // present one request and wait for it to be taken
   task send_sample(input sample_type s);
      req_tvalid <= 1'b1;
      req_tdata  <= {s.ticks, s.temperature};
      req_tuser  <= {s.die_error, s.boost};
      do @(posedge clock); while (!req_tready);
      board.note_sample(s);
   endtask

   // sender gap, cycles must be at least one
   task pause_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold off until every expected response has come
   task drain_responses();
      pause_sender(1);
      while (board.pending_caps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register write, valid stays up for a following write
   task write_reg(input reg_idx_type idx, input logic [FreqW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_register(idx, value);
   endtask

   // write all registers, thresholds carry random upper bits
   task configure(input logic [FreqW-1:0] peak, input logic [FreqW-1:0] lvl0,
                  input logic [FreqW-1:0] lvl1, input logic [FreqW-1:0] flr,
                  input int clr, input int b0, input int b1, input int b2);
      logic [FreqW-1:0] v;
      write_reg(REG_PEAK, peak);
      write_reg(REG_LEVEL0, lvl0);
      write_reg(REG_LEVEL1, lvl1);
      write_reg(REG_FLOOR, flr);
      v = FreqW'($urandom()); v[ThrW-1:0] = ThrW'(clr); write_reg(REG_CLEAR, v);
      v = FreqW'($urandom()); v[ThrW-1:0] = ThrW'(b0);  write_reg(REG_BAND0, v);
      v = FreqW'($urandom()); v[ThrW-1:0] = ThrW'(b1);  write_reg(REG_BAND1, v);
      v = FreqW'($urandom()); v[ThrW-1:0] = ThrW'(b2);  write_reg(REG_BAND2, v);
      csr_valid <= 1'b0;
      @(posedge clock);
      thr_now[0] = clr;
      thr_now[1] = b0;
      thr_now[2] = b1;
      thr_now[3] = b2;
   endtask

   // directed request from the current counters
   task probe(input bit boost, input bit die, input int temp);
      sample_type s;
      s.boost       = boost;
      s.die_error   = die;
      s.temperature = 8'(temp);
      s.ticks       = tick_now;
      // boost must ignore the counters, so send junk there
      if (boost)
         for (int i = 0; i < NCount; i++) s.ticks[i] = $urandom();
      send_sample(s);
   endtask

   task tick_add(input int unsigned user_d, input int unsigned idle_d);
      tick_now[0] = tick_now[0] + user_d;
      tick_now[IdleIdx] = tick_now[IdleIdx] + idle_d;
   endtask

   // random request: mostly plausible counter progress near the thresholds
   task make_random_sample(output sample_type s);
      int kind, busy, off, t;
      kind = $urandom_range(0, 99);
      busy = $urandom_range(0, 100);
      s.boost     = (kind < 8);
      s.die_error = ($urandom_range(0, 99) < 6);
      if (s.boost) begin
         for (int i = 0; i < NCount; i++) s.ticks[i] = $urandom();
      end else begin
         if (kind < 14) begin
            // unrelated counter values, large and wrapping deltas
            for (int i = 0; i < NCount; i++) tick_now[i] = $urandom();
         end else if (kind >= 18) begin
            for (int i = 0; i < NCount; i++)
               if (i == IdleIdx) tick_now[i] = tick_now[i] + $urandom_range(0, 1000);
               else              tick_now[i] = tick_now[i] + $urandom_range(0, busy * 3);
         end
         // otherwise the counters stay put and the total is zero
         s.ticks = tick_now;
      end
      if ($urandom_range(0, 99) < 70) begin
         off = $urandom_range(0, 6);
         t   = thr_now[$urandom_range(0, 3)] + off - 3;
         if (t > 127) t = 127;
      end else begin
         t = int'($urandom_range(0, 255)) - 128;
      end
      s.temperature = 8'(t);
   endtask

   // random requests in bursts with gaps, or back to back when steady
   task run_random(input int count, input bit steady);
      sample_type s;
      int burst_left;
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!steady) pause_sender($urandom_range(1, 70));
         end
         burst_left--;
         make_random_sample(s);
         send_sample(s);
      end
   endtask

   // main sequence
   initial begin
      int clr, b0, b1;
      board    = new();
      tick_now = '0;
      thr_now[0] = ClearRst;
      thr_now[1] = Band0Rst;
      thr_now[2] = Band1Rst;
      thr_now[3] = Band2Rst;
      @(posedge clock);
      while (reset) @(posedge clock);

      // directed cases at the default settings
      probe(0, 0, 25);                      // zero total holds the reset load
      tick_add(0, 100);    probe(0, 0, 25); // fully idle
      tick_add(100, 0);    probe(0, 0, 25); // fully busy, cool
      tick_add(30, 70);    probe(0, 0, 25); // middle load
      tick_add(4999, 5001); probe(0, 0, 25); // just under half
      tick_add(50, 50);    probe(0, 0, 25); // exactly half
      tick_add(21, 79);    probe(0, 0, 25);
      tick_add(20, 80);    probe(0, 0, 25);
      probe(1, 1, 127);                     // boost wins over everything
      tick_add(100, 0);    probe(0, 0, 66); // second band sets under
      tick_add(100, 0);    probe(0, 0, 72); // third band sets min
      tick_add(100, 0);    probe(0, 0, 68);
      tick_add(100, 0);    probe(0, 0, 62);
      tick_add(100, 0);    probe(0, 0, 59); // below clear
      tick_add(100, 0);    probe(0, 0, 80); // danger
      tick_add(100, 0);    probe(0, 0, 127);
      tick_add(100, 0);    probe(0, 0, 70); // danger is sticky
      tick_add(100, 0);    probe(0, 0, 64);
      tick_add(100, 0);    probe(0, 0, -128);
      tick_add(100, 0);    probe(0, 1, 25); // die error forces the floor
      for (int i = 0; i < NCount; i++) tick_now[i] = 32'hFFFF_FF00;
      probe(0, 0, 25);
      for (int i = 0; i < NCount; i++) tick_now[i] = tick_now[i] + 32'h100;
      probe(0, 0, 25);                      // every counter wraps
      tick_now = '1;
      probe(0, 0, 25);
      drain_responses();

      // random settings with ascending thresholds
      clr = $urandom_range(0, 60);
      b0  = clr + $urandom_range(0, 20);
      b1  = b0 + $urandom_range(0, 20);
      configure(FreqW'($urandom()), FreqW'($urandom()), FreqW'($urandom()),
                FreqW'($urandom()), clr, b0, b1, b1 + $urandom_range(0, 20));
      run_random(350, 0);
      drain_responses();

      // extreme values, no sender gaps
      configure('1, '0, '1, '0, 0, 0, 127, 127);
      run_random(350, 1);
      drain_responses();

      // thresholds in any order
      configure(FreqW'($urandom()), FreqW'($urandom()), FreqW'($urandom()),
                FreqW'($urandom()), $urandom_range(0, 127), $urandom_range(0, 127),
                $urandom_range(0, 127), $urandom_range(0, 127));
      run_random(350, 0);
      drain_responses();

      // highest thresholds
      configure('0, '1, FreqW'(1), FreqW'(22'h3F_FFFE), 127, 127, 127, 127);
      run_random(350, 0);
      drain_responses();

      // back to the defaults
      configure(PeakRst, Level0Rst, Level1Rst, FloorRst, ClearRst, Band0Rst, Band1Rst,
                Band2Rst);
      run_random(350, 0);
      drain_responses();

      // let any stray response show up
      repeat (60) @(posedge clock);
      if (board.errors == 0 && board.pending_caps.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
